[rtl/sequential_list_engine_unit_defines.svh]
// ----------------------------------------------------------------------------
// Sequential list engine: assertion macros
// Shared helpers for the concurrent checks of the list engine.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SLE_ASSERT_SAME(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SLE_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// Sequential list engine package
// Operation codes, status codes, the limit reset value and the controller state type.
// ----------------------------------------------------------------------------
package sle_pkg;

	// Operation codes
	localparam logic [2:0] FN_CLEAR  = 3'd0;
	localparam logic [2:0] FN_GET    = 3'd1;
	localparam logic [2:0] FN_LOCATE = 3'd2;
	localparam logic [2:0] FN_PRIOR  = 3'd3;
	localparam logic [2:0] FN_NEXT   = 3'd4;
	localparam logic [2:0] FN_INSERT = 3'd5;
	localparam logic [2:0] FN_DELETE = 3'd6;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_POS  = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// Reset value of the list limit register
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET,
		ST_SCAN,
		ST_NEXT,
		ST_DEL,
		ST_MOVE,
		ST_DONE
	} state_t;

endpackage

[rtl/sle_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/sequential_list_engine_unit.sv]
// Ordered list of signed 32-bit words kept in a CAPACITY-entry RAM with
// registered read data. One request word is taken at a time; the next request
// word is taken as soon as the current one is finished, even while its result
// word still waits at the output register. Locate, prior and next make one RAM
// read per entry searched. Insert and delete shift the entries behind the
// position, one entry moved per cycle with read and write overlapped on the two
// RAM ports. A result word held back at the output keeps the next request in its
// done state. The RAM needs no clearing pass after reset; entries at or beyond
// the length are never used.
// ----------------------------------------------------------------------------
// Sequential list engine
// Clear, get, locate, prior, next, insert and delete on a RAM-held list.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_unit_defines.svh"

module sequential_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] data_out,
	output logic [4:0]         found_position,
	output logic [4:0]         list_length,
	output logic               is_empty
);

	localparam int AW = $clog2(CAPACITY);
	// Largest length the 5-bit count may reach
	localparam logic [4:0] CapLim = (CAPACITY > 31) ? 5'd31 : 5'(CAPACITY);

	sle_pkg::state_t state_q, state_d;

	logic [4:0]  limit_q;
	logic [4:0]  count_q, count_d;
	logic [2:0]  func_q, func_d;
	logic [31:0] key_q, key_d;
	logic [4:0]  k_q, k_d;
	logic [4:0]  rem_q, rem_d;
	logic        pend_q, pend_d;
	logic [4:0]  pdst_q, pdst_d;
	logic [4:0]  ins_addr_q, ins_addr_d;
	logic [31:0] prev_q, prev_d;
	logic [1:0]  res_status_q, res_status_d;
	logic [31:0] res_data_q, res_data_d;
	logic [4:0]  res_found_q, res_found_d;

	logic          out_valid_q;
	logic          out_load;
	logic          in_acc;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic [4:0] eff_limit;
	logic [4:0] pos_m1;
	logic [4:0] k_nx;
	logic       pos_ok_rd, pos_ok_ins;
	logic       is_ins;

	sle_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request checks
	assign eff_limit  = (limit_q > CapLim) ? CapLim : limit_q;
	assign pos_m1     = position - 5'd1;
	assign pos_ok_rd  = (position != 5'd0) && (position <= count_q);
	assign pos_ok_ins = (position != 5'd0) && ({1'b0, position} <= ({1'b0, count_q} + 6'd1));
	assign k_nx       = k_q + 5'd1;
	assign is_ins     = (func_q == sle_pkg::FN_INSERT);

	assign in_stall = (state_q != sle_pkg::ST_IDLE);
	assign in_acc   = in_valid && (state_q == sle_pkg::ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sle_pkg::ST_IDLE;
			count_q <= '0;
			limit_q <= sle_pkg::LIMIT_RESET;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		func_q       <= func_d;
		key_q        <= key_d;
		k_q          <= k_d;
		rem_q        <= rem_d;
		pdst_q       <= pdst_d;
		ins_addr_q   <= ins_addr_d;
		prev_q       <= prev_d;
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		res_found_q  <= res_found_d;
	end

	// Next state, RAM control and working values
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		func_d       = func_q;
		key_d        = key_q;
		k_d          = k_q;
		rem_d        = rem_q;
		pend_d       = pend_q;
		pdst_d       = pdst_q;
		ins_addr_d   = ins_addr_q;
		prev_d       = prev_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		res_found_d  = res_found_q;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = '0;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		out_load     = 1'b0;

		case (state_q)
			sle_pkg::ST_IDLE: begin
				if (in_acc) begin
					func_d       = func;
					key_d        = value;
					res_status_d = sle_pkg::STAT_OK;
					res_data_d   = '0;
					res_found_d  = '0;
					state_d      = sle_pkg::ST_DONE;
					case (func)
						sle_pkg::FN_CLEAR: begin
							count_d = '0;
						end
						sle_pkg::FN_GET: begin
							if (pos_ok_rd) begin
								ram_re    = 1'b1;
								ram_raddr = AW'(pos_m1);
								state_d   = sle_pkg::ST_GET;
							end else begin
								res_status_d = sle_pkg::STAT_BAD_POS;
							end
						end
						sle_pkg::FN_LOCATE, sle_pkg::FN_PRIOR, sle_pkg::FN_NEXT: begin
							if (count_q == 5'd0) begin
								res_status_d = sle_pkg::STAT_NOTFOUND;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								k_d       = '0;
								state_d   = sle_pkg::ST_SCAN;
							end
						end
						sle_pkg::FN_INSERT: begin
							if (!pos_ok_ins) begin
								res_status_d = sle_pkg::STAT_BAD_POS;
							end else if (count_q >= eff_limit) begin
								res_status_d = sle_pkg::STAT_FULL;
							end else begin
								// shift entries pos-1 .. count-1 up by one, top first
								rem_d      = count_q - position + 5'd1;
								k_d        = count_q - 5'd1;
								pend_d     = 1'b0;
								ins_addr_d = pos_m1;
								state_d    = sle_pkg::ST_MOVE;
							end
						end
						sle_pkg::FN_DELETE: begin
							if (pos_ok_rd) begin
								ram_re    = 1'b1;
								ram_raddr = AW'(pos_m1);
								state_d   = sle_pkg::ST_DEL;
							end else begin
								res_status_d = sle_pkg::STAT_BAD_POS;
							end
						end
						default: begin
							state_d = sle_pkg::ST_DONE;
						end
					endcase
				end
			end
			sle_pkg::ST_GET: begin
				res_data_d = ram_rdata;
				state_d    = sle_pkg::ST_DONE;
			end
			sle_pkg::ST_SCAN: begin
				// compare entry k while fetching entry k+1
				ram_re    = 1'b1;
				ram_raddr = AW'(k_nx);
				if (ram_rdata == key_q) begin
					state_d = sle_pkg::ST_DONE;
					case (func_q)
						sle_pkg::FN_LOCATE: begin
							res_data_d  = ram_rdata;
							res_found_d = k_nx;
						end
						sle_pkg::FN_PRIOR: begin
							if (k_q != 5'd0) begin
								res_data_d = prev_q;
							end else begin
								res_status_d = sle_pkg::STAT_NOTFOUND;
							end
						end
						sle_pkg::FN_NEXT: begin
							if (k_nx < count_q) begin
								state_d = sle_pkg::ST_NEXT;
							end else begin
								res_status_d = sle_pkg::STAT_NOTFOUND;
							end
						end
						default: begin
							res_status_d = sle_pkg::STAT_OK;
						end
					endcase
				end else begin
					prev_d = ram_rdata;
					if (k_nx < count_q) begin
						k_d = k_nx;
					end else begin
						res_status_d = sle_pkg::STAT_NOTFOUND;
						state_d      = sle_pkg::ST_DONE;
					end
				end
			end
			sle_pkg::ST_NEXT: begin
				res_data_d = ram_rdata;
				state_d    = sle_pkg::ST_DONE;
			end
			sle_pkg::ST_DEL: begin
				// hold removed word, then shift entries pos .. count-1 down by one
				res_data_d = ram_rdata;
				k_d        = ins_addr_q;
				rem_d      = rem_q;
				pend_d     = 1'b0;
				state_d    = sle_pkg::ST_MOVE;
			end
			sle_pkg::ST_MOVE: begin
				// retire the word read last cycle
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(pdst_q);
					ram_wdata = ram_rdata;
				end
				if (rem_q != 5'd0) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(k_q);
					pend_d    = 1'b1;
					pdst_d    = is_ins ? (k_q + 5'd1) : (k_q - 5'd1);
					k_d       = is_ins ? (k_q - 5'd1) : (k_q + 5'd1);
					rem_d     = rem_q - 5'd1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						if (is_ins) begin
							ram_we     = 1'b1;
							ram_waddr  = AW'(ins_addr_q);
							ram_wdata  = key_q;
							count_d    = count_q + 5'd1;
							res_data_d = key_q;
						end else begin
							count_d = count_q - 5'd1;
						end
						state_d = sle_pkg::ST_DONE;
					end
				end
			end
			sle_pkg::ST_DONE: begin
				// hand over once the output register is free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = sle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sle_pkg::ST_IDLE;
			end
		endcase

		// delete setup: source starts at pos, count-pos entries to move
		if (in_acc && (func == sle_pkg::FN_DELETE) && pos_ok_rd) begin
			ins_addr_d = position;
			rem_d      = count_q - position;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status         <= res_status_q;
			data_out       <= res_data_q;
			found_position <= res_found_q;
			list_length    <= count_q;
			is_empty       <= (count_q == 5'd0);
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	`SLE_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CapLim,
		"list length beyond capacity")
	`SLE_ASSERT_SAME(a_move_no_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr,
		"shift reads and writes the same entry")
	`SLE_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_acc, state_q != sle_pkg::ST_IDLE,
		"accepted word did not start work")
	`SLE_ASSERT_NEXT(a_idle_count, clk, arst_n, (state_q == sle_pkg::ST_IDLE) && !in_acc,
		$stable(count_q), "length changed while idle")
	`SLE_ASSERT_SAME(a_empty_flag, clk, arst_n, out_valid_q,
		is_empty == (list_length == 5'd0), "empty flag disagrees with length")

endmodule

[verif/sle_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list engine checker
// Watches the config, request and result ports of the list engine. It keeps
// a shadow copy of the list and its limit, works out the result word of
// every accepted request word, and compares the result words in order.
// ----------------------------------------------------------------------------
module sle_list_checker #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  func,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] data_out,
	input  logic [4:0]  found_position,
	input  logic [4:0]  list_length,
	input  logic        is_empty,
	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          full_refusals
);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data;
		logic [4:0]  found;
		logic [4:0]  length;
		logic        empty;
	} list_result_t;

	logic [31:0]  shadow_store [CAPACITY];
	int           shadow_count;
	logic [4:0]   shadow_limit;
	list_result_t expected_q [$];

	// Find the index of the first entry equal to v, or the count if none
	function automatic int find_first(logic [31:0] v);
		for (int k = 0; k < shadow_count; k++) begin
			if (shadow_store[k] == v)
				return k;
		end
		return shadow_count;
	endfunction

	// Apply one request word to the shadow list and build its result word
	function automatic list_result_t apply_request(logic [2:0] f, logic [4:0] p,
			logic [31:0] v);
		list_result_t r;
		int k;
		int pi;
		int lim;
		r = '0;
		pi = int'(p);
		lim = (int'(shadow_limit) > CAPACITY) ? CAPACITY : int'(shadow_limit);
		case (f)
			sle_pkg::FN_CLEAR: begin
				shadow_count = 0;
			end
			sle_pkg::FN_GET: begin
				if (pi < 1 || pi > shadow_count)
					r.status = sle_pkg::STAT_BAD_POS;
				else
					r.data = shadow_store[pi - 1];
			end
			sle_pkg::FN_LOCATE: begin
				k = find_first(v);
				if (k < shadow_count) begin
					r.found = 5'(k + 1);
					r.data = shadow_store[k];
				end else begin
					r.status = sle_pkg::STAT_NOTFOUND;
				end
			end
			sle_pkg::FN_PRIOR: begin
				k = find_first(v);
				if (k < shadow_count && k > 0)
					r.data = shadow_store[k - 1];
				else
					r.status = sle_pkg::STAT_NOTFOUND;
			end
			sle_pkg::FN_NEXT: begin
				k = find_first(v);
				if (k + 1 < shadow_count)
					r.data = shadow_store[k + 1];
				else
					r.status = sle_pkg::STAT_NOTFOUND;
			end
			sle_pkg::FN_INSERT: begin
				// position is checked before the limit
				if (pi < 1 || pi > shadow_count + 1) begin
					r.status = sle_pkg::STAT_BAD_POS;
				end else if (shadow_count >= lim) begin
					r.status = sle_pkg::STAT_FULL;
					full_refusals++;
				end else begin
					for (k = shadow_count; k > pi - 1; k--)
						shadow_store[k] = shadow_store[k - 1];
					shadow_store[pi - 1] = v;
					shadow_count++;
					r.data = v;
				end
			end
			sle_pkg::FN_DELETE: begin
				if (pi < 1 || pi > shadow_count) begin
					r.status = sle_pkg::STAT_BAD_POS;
				end else begin
					r.data = shadow_store[pi - 1];
					for (k = pi - 1; k + 1 < shadow_count; k++)
						shadow_store[k] = shadow_store[k + 1];
					shadow_count--;
				end
			end
			default: begin
				// unused code: no change, status ok, data zero
			end
		endcase
		r.length = 5'(shadow_count);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	// Compare one field and report a difference
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Track the limit, check result words, queue predictions
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_limit = sle_pkg::LIMIT_RESET;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
			words_checked = 0;
			full_refusals = 0;
		end else begin
			if (cfg_wr_en)
				shadow_limit = cfg_wr_data;
			// results of this edge belong to earlier requests, so check them first
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t ns: result word with none expected, actual status %0h data %0h",
						$time, status, data_out);
				end else begin
					want = expected_q.pop_front();
					words_checked++;
					check_field("status", want.status, status);
					check_field("data_out", want.data, data_out);
					check_field("found_position", want.found, found_position);
					check_field("list_length", want.length, list_length);
					check_field("is_empty", want.empty, is_empty);
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(apply_request(func, position, value));
			pending = expected_q.size();
		end
	end

endmodule

[verif/sequential_list_engine_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives directed and random request words into the list engine under
// several list limits and idle patterns on both channels. A checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit_tb;

	localparam logic [2:0] FN_UNUSED     = 3'd7;
	localparam int         HOLD_CYCLES   = 90;
	localparam int         SETTLE_CYCLES = 24;
	localparam int         SEGMENTS      = 7;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [4:0]         cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         func;
	logic [4:0]         position;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [4:0]         found_position;
	logic [4:0]         list_length;
	logic               is_empty;

	int          fail_count;
	int          pending;
	int          words_checked;
	int          full_refusals;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          holds_asked;
	int          words_sent;
	int          settings_used;
	logic [31:0] value_pool [8];

	sequential_list_engine_unit #(
		.CAPACITY(16)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_out(data_out),
		.found_position(found_position),
		.list_length(list_length),
		.is_empty(is_empty)
	);

	sle_list_checker #(
		.CAPACITY(16)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data_out(data_out),
		.found_position(found_position),
		.list_length(list_length),
		.is_empty(is_empty),
		.fail_count(fail_count),
		.pending(pending),
		.words_checked(words_checked),
		.full_refusals(full_refusals)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stalls, plus a long hold whenever one is asked for
	initial begin
		int holds_done;
		int held;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					out_stall = 1'b1;
					@(negedge clk);
				end
			end
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Offer one request word and hold it until accepted
	task automatic send_word(input logic [2:0] f, input logic [4:0] p, input logic [31:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		position = p;
		value = v;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Drop valid and wait until every result word is back, then let the block settle
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the list limit register
	task automatic write_limit(input logic [4:0] lim);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = lim;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		settings_used++;
	endtask

	// Build a random request word: mostly inserts and searches on a small value pool
	task automatic send_random_word();
		int roll;
		logic [2:0] f;
		logic [4:0] p;
		logic [31:0] v;
		roll = $urandom_range(0, 99);
		if (roll < 41)
			f = sle_pkg::FN_INSERT;
		else if (roll < 55)
			f = sle_pkg::FN_DELETE;
		else if (roll < 65)
			f = sle_pkg::FN_GET;
		else if (roll < 74)
			f = sle_pkg::FN_LOCATE;
		else if (roll < 83)
			f = sle_pkg::FN_PRIOR;
		else if (roll < 92)
			f = sle_pkg::FN_NEXT;
		else if (roll < 93)
			f = sle_pkg::FN_CLEAR;
		else if (roll < 95)
			f = FN_UNUSED;
		else
			f = 3'($urandom_range(0, 7));
		roll = $urandom_range(0, 99);
		if (roll < 50)
			p = 5'($urandom_range(1, 3));
		else if (roll < 85)
			p = 5'($urandom_range(1, 17));
		else
			p = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 99) < 65)
			v = value_pool[$urandom_range(0, 7)];
		else
			v = $urandom;
		send_word(f, p, v);
	endtask

	// Stimulus and verdict
	initial begin
		int seg;
		int n;
		logic [4:0] seg_limit [SEGMENTS];
		int seg_items [SEGMENTS];
		seg_limit = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'd12};
		seg_items = '{220, 150, 220, 40, 200, 220, 200};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		func = sle_pkg::FN_CLEAR;
		position = '0;
		value = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holds_asked = 0;
		words_sent = 0;
		settings_used = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: operations and corner cases at the reset limit
		send_word(sle_pkg::FN_CLEAR, 5'd0, 32'h0);
		send_word(sle_pkg::FN_GET, 5'd0, 32'h0);
		send_word(sle_pkg::FN_INSERT, 5'd1, 32'h7FFF_FFFF);
		send_word(sle_pkg::FN_INSERT, 5'd1, 32'h8000_0000);
		send_word(sle_pkg::FN_INSERT, 5'd3, 32'h0000_0000);
		send_word(sle_pkg::FN_INSERT, 5'd5, 32'h1234_5678);
		send_word(sle_pkg::FN_INSERT, 5'd0, 32'h1234_5678);
		send_word(sle_pkg::FN_INSERT, 5'd31, 32'hFFFF_FFFF);
		send_word(sle_pkg::FN_GET, 5'd3, 32'h0);
		send_word(sle_pkg::FN_GET, 5'd4, 32'h0);
		send_word(sle_pkg::FN_LOCATE, 5'd0, 32'h7FFF_FFFF);
		send_word(sle_pkg::FN_LOCATE, 5'd0, 32'h0001_2345);
		// neighbor of a first and a last match, and of no match
		send_word(sle_pkg::FN_PRIOR, 5'd0, 32'h8000_0000);
		send_word(sle_pkg::FN_PRIOR, 5'd0, 32'h0000_0000);
		send_word(sle_pkg::FN_NEXT, 5'd0, 32'h8000_0000);
		send_word(sle_pkg::FN_NEXT, 5'd0, 32'h0000_0000);
		send_word(sle_pkg::FN_NEXT, 5'd0, 32'h5A5A_5A5A);
		send_word(FN_UNUSED, 5'd31, 32'hFFFF_FFFF);
		send_word(sle_pkg::FN_DELETE, 5'd2, 32'h0);
		send_word(sle_pkg::FN_DELETE, 5'd1, 32'h0);
		send_word(sle_pkg::FN_CLEAR, 5'd0, 32'h0);
		drain_results();

		// Limit zero: valid position refused as full, bad position reported first
		write_limit(5'd0);
		send_word(sle_pkg::FN_INSERT, 5'd1, 32'hCAFE_0001);
		send_word(sle_pkg::FN_INSERT, 5'd2, 32'hCAFE_0002);
		drain_results();

		// Limit lowered below the length: entries stay, inserts refused
		write_limit(5'd31);
		send_word(sle_pkg::FN_INSERT, 5'd1, 32'h0000_0011);
		send_word(sle_pkg::FN_INSERT, 5'd2, 32'h0000_0022);
		drain_results();
		write_limit(5'd1);
		send_word(sle_pkg::FN_INSERT, 5'd1, 32'h0000_0033);
		send_word(sle_pkg::FN_GET, 5'd2, 32'h0);
		drain_results();

		// Random segments under different limits and idle patterns
		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 27;
				recv_idle_pct = 56;
			end else if (seg < 5) begin
				send_idle_pct = 56;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (seg == 4)
				write_limit(5'($urandom_range(2, 15)));
			else
				write_limit(seg_limit[seg]);
			value_pool[0] = 32'h8000_0000;
			value_pool[1] = 32'h7FFF_FFFF;
			value_pool[2] = 32'h0000_0000;
			value_pool[3] = 32'hFFFF_FFFF;
			value_pool[4] = 32'h0000_0001;
			for (n = 5; n < 8; n++)
				value_pool[n] = $urandom;
			for (n = 0; n < seg_items[seg]; n++) begin
				// fill the block while results are held back
				if (n == 60 && (seg == 2 || seg == 5))
					holds_asked++;
				// pause the sender until every result is back
				if (n == 110 && seg == 0)
					drain_results();
				send_random_word();
			end
			drain_results();
		end

		if (pending != 0)
			$display("%0t ns: %0d result words never arrived", $time, pending);
		$display("Run covered %0d request words under %0d limit settings.",
			words_sent, settings_used);
		$display("%0d result words compared, %0d inserts refused on a full list.",
			words_checked, full_refusals);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
